[design/assert_macros.svh]
// Assertion helpers used by the checker.
// Guarded so the header can be pulled in more than once.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted
`define HAB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define HAB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/hab_pkg.sv]
// ----------------------------------------------------------------------------
// hab_pkg
// Shared types, codes and sizes for the backend selector.
// ----------------------------------------------------------------------------
package hab_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_BACKENDS = 16;
  localparam int DEF_RING_DEPTH   = 2048;

  // Fixed field widths
  localparam int NW     = 5;   // backend count / walk counter
  localparam int BIW    = 4;   // backend index
  localparam int HSLOTS = 16;  // health slots reachable by a 4-bit index
  localparam int CFGW   = 16;  // widest config register

  typedef enum logic [2:0] {
    FN_TICK    = 3'd0,
    FN_SELECT  = 3'd1,
    FN_SUCCESS = 3'd2,
    FN_FAILURE = 3'd3,
    FN_CLEAR   = 3'd4,
    FN_INSERT  = 3'd5,
    FN_RSVD6   = 3'd6,
    FN_RSVD7   = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_RING     = 2'd0,
    ST_RR       = 2'd1,
    ST_FALLBACK = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_NUM_BACKENDS = 2'd0,
    CFG_THRESHOLD    = 2'd1,
    CFG_COOLDOWN     = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RD_MID,
    RD_POS,
    RD_LO,
    RD_PREV
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_BS_ISSUE,
    S_BS_CMP,
    S_WK_ISSUE,
    S_WK_CHK,
    S_RR,
    S_DUP_ISSUE,
    S_DUP_CHK,
    S_SH_ISSUE,
    S_SH_WR,
    S_RES
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    tick;
    logic    report_ok;
    logic    report_fail;
    logic    clear;
    logic    bs_init;
    logic    bs_step;
    logic    wk_init;
    logic    wk_wrap;
    logic    wk_next;
    logic    wk_hit;
    logic    rr_init;
    logic    rr_try;
    logic    sh_init;
    logic    sh_move;
    logic    ins_write;
    logic    res_set;
    logic    res_load;
    status_t res_status;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  present;
    logic  n_zero;
    logic  ring_empty;
    logic  ring_full;
    logic  lo_lt_hi;
    logic  pos_lt_cnt;
    logic  dup_hit;
    logic  walk_done;
    logic  owner_ok;
    logic  rr_avail;
    logic  sh_done;
    logic  out_full;
  } dp_sts_t;

endpackage

[design/hab_in_if.sv]
// ----------------------------------------------------------------------------
// hab_in_if
// Request channel: valid/ready with the request payload.
// ----------------------------------------------------------------------------
interface hab_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic        client_present;
  logic [31:0] client_hash;
  logic [3:0]  backend_index;
  logic [31:0] ring_point;

  modport source (output valid, func, client_present, client_hash, backend_index,
                  ring_point, input ready);
  modport sink   (input valid, func, client_present, client_hash, backend_index,
                  ring_point, output ready);
endinterface

[design/hab_out_if.sv]
// ----------------------------------------------------------------------------
// hab_out_if
// Result channel: valid/ready with status and chosen backend.
// ----------------------------------------------------------------------------
interface hab_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] chosen_backend;

  modport source (output valid, status, chosen_backend, input ready);
  modport sink   (input valid, status, chosen_backend, output ready);
endinterface

[design/health_aware_backend_selector_core.sv]
// ----------------------------------------------------------------------------
// health_aware_backend_selector_core
// Picks a backend per select from a hash ring, with round-robin and backend-0 fallback.
// ----------------------------------------------------------------------------
// One request at a time. A tick, report or clear acts in the dispatch state.
// A select with no backends goes straight to the result. A select without a
// ring search goes to round robin. A select that searches the ring runs a
// binary search over the ring points, then walks the ring from the found
// point until it meets an owner that is in range and not cooling down; a
// walk that finds nothing goes on to round robin, and when no attempt
// succeeds the pick falls back to backend 0. An insert runs the same search,
// checks the found point for a duplicate when the new point lands below the
// top of the ring, and then moves ring points up one by one to make room
// before it writes the new point. A duplicate insert, or an insert on a full
// ring, leaves the ring as it is. Every search probe and walk step is a read
// on the ring memory's single registered read port followed by a wait, and
// each moved entry is a read followed by a write. A result sits in an output
// register, so the next request is taken while it waits.
module health_aware_backend_selector_core #(
  parameter int MAX_BACKENDS = hab_pkg::DEF_MAX_BACKENDS,
  parameter int RING_DEPTH   = hab_pkg::DEF_RING_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  hab_in_if.sink                   in_ch,
  hab_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [hab_pkg::CFGW-1:0] cfg_wdata
);
  import hab_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  hab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hab_dp #(
    .MAX_BACKENDS (MAX_BACKENDS),
    .RING_DEPTH   (RING_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_ch.func),
    .in_client_present  (in_ch.client_present),
    .in_client_hash     (in_ch.client_hash),
    .in_backend_index   (in_ch.backend_index),
    .in_ring_point      (in_ch.ring_point),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_chosen_backend (out_ch.chosen_backend)
  );

endmodule

[design/hab_ctrl.sv]
// ----------------------------------------------------------------------------
// hab_ctrl
// Sequencer: walks each request through search, walk, scan and shift steps.
// ----------------------------------------------------------------------------
module hab_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hab_pkg::dp_sts_t sts,
  output hab_pkg::dp_cmd_t cmd
);
  import hab_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (sts.func)
          FN_SELECT: begin
            if (sts.n_zero) state_nxt = S_RES;
            else if (sts.present && !sts.ring_empty) state_nxt = S_BS_ISSUE;
            else state_nxt = S_RR;
          end
          FN_INSERT: state_nxt = sts.ring_full ? S_IDLE : S_BS_ISSUE;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_BS_ISSUE: begin
        if (sts.lo_lt_hi) state_nxt = S_BS_CMP;
        else if (sts.func == FN_SELECT) state_nxt = S_WK_ISSUE;
        else state_nxt = S_DUP_ISSUE;
      end
      S_BS_CMP:   state_nxt = S_BS_ISSUE;
      S_WK_ISSUE: state_nxt = sts.walk_done ? S_RR : S_WK_CHK;
      S_WK_CHK:   state_nxt = sts.owner_ok ? S_RES : S_WK_ISSUE;
      S_RR:       if (sts.walk_done || sts.rr_avail) state_nxt = S_RES;
      S_DUP_ISSUE: state_nxt = sts.pos_lt_cnt ? S_DUP_CHK : S_SH_ISSUE;
      S_DUP_CHK:  state_nxt = sts.dup_hit ? S_IDLE : S_SH_ISSUE;
      S_SH_ISSUE: state_nxt = sts.sh_done ? S_IDLE : S_SH_WR;
      S_SH_WR:    state_nxt = S_SH_ISSUE;
      S_RES:      if (!sts.out_full) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_RING;
    cmd.rd_sel     = RD_MID;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_DISPATCH: begin
        unique case (sts.func)
          FN_TICK:    cmd.tick        = 1'b1;
          FN_SUCCESS: cmd.report_ok   = 1'b1;
          FN_FAILURE: cmd.report_fail = 1'b1;
          FN_CLEAR:   cmd.clear       = 1'b1;
          FN_SELECT: begin
            if (sts.n_zero) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NONE;
            end else if (sts.present && !sts.ring_empty) begin
              cmd.bs_init = 1'b1;
            end else begin
              cmd.rr_init = 1'b1;
            end
          end
          FN_INSERT: cmd.bs_init = !sts.ring_full;
          default: ;
        endcase
      end
      S_BS_ISSUE: begin
        cmd.rd_sel = RD_MID;
        if (!sts.lo_lt_hi && sts.func == FN_SELECT) cmd.wk_init = 1'b1;
      end
      S_BS_CMP: cmd.bs_step = 1'b1;
      S_WK_ISSUE: begin
        cmd.rd_sel = RD_POS;
        if (sts.walk_done) cmd.rr_init = 1'b1;
        else               cmd.wk_wrap = 1'b1;
      end
      S_WK_CHK: begin
        if (sts.owner_ok) begin
          cmd.wk_hit     = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_RING;
        end else begin
          cmd.wk_next = 1'b1;
        end
      end
      S_RR: begin
        if (sts.walk_done) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FALLBACK;
        end else begin
          cmd.rr_try = 1'b1;
          if (sts.rr_avail) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_RR;
          end
        end
      end
      S_DUP_ISSUE: begin
        cmd.rd_sel  = RD_LO;
        cmd.sh_init = !sts.pos_lt_cnt;
      end
      S_DUP_CHK: cmd.sh_init = !sts.dup_hit;
      S_SH_ISSUE: begin
        cmd.rd_sel    = RD_PREV;
        cmd.ins_write = sts.sh_done;
      end
      S_SH_WR: cmd.sh_move = 1'b1;
      S_RES:   cmd.res_load = !sts.out_full;
      default: ;
    endcase
  end

endmodule

[design/hab_dp.sv]
// ----------------------------------------------------------------------------
// hab_dp
// Datapath: config, ring memory, search/walk pointers, health and result.
// ----------------------------------------------------------------------------
module hab_dp #(
  parameter int MAX_BACKENDS = hab_pkg::DEF_MAX_BACKENDS,
  parameter int RING_DEPTH   = hab_pkg::DEF_RING_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hab_pkg::dp_cmd_t       cmd,
  output hab_pkg::dp_sts_t       sts,
  input  logic [2:0]             in_func,
  input  logic                   in_client_present,
  input  logic [31:0]            in_client_hash,
  input  logic [3:0]             in_backend_index,
  input  logic [31:0]            in_ring_point,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [hab_pkg::CFGW-1:0] cfg_wdata,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [3:0]             out_chosen_backend
);
  import hab_pkg::*;

  localparam int RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RCW = $clog2(RING_DEPTH + 1);

  typedef struct packed {
    logic [31:0]    hash;
    logic [BIW-1:0] owner;
  } ring_ent_t;

  // Latched request
  func_t          func_r;
  logic           present_r;
  logic [31:0]    key_r;
  logic [BIW-1:0] bidx_r;

  // Config
  logic [NW-1:0]  nb_r;
  logic [7:0]     thr_r;
  logic [15:0]    ticks_r;

  // Ring and pointers
  ring_ent_t      mem [RING_DEPTH];
  ring_ent_t      rd_data_r;
  logic [RCW-1:0] count_r, lo_r, hi_r, pos_r, j_r, mid, pos_wrap;
  logic [NW-1:0]  rr_r, i_r, n_act, cand;
  logic [RAW-1:0] rd_addr;

  // Health
  logic [7:0]     fail_r  [HSLOTS];
  logic           armed_r [HSLOTS];
  logic [15:0]    left_r  [HSLOTS];

  // Result
  status_t        res_status_r;
  logic [BIW-1:0] res_be_r;
  logic           out_valid_r;
  status_t        out_status_r;
  logic [BIW-1:0] out_be_r;

  logic [BIW-1:0] owner;
  logic           owner_busy, cand_busy, bidx_used;
  logic [7:0]     fail_inc;
  logic [NW:0]    cand_inc;

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r    <= func_t'(in_func);
      present_r <= in_client_present;
      key_r     <= (func_t'(in_func) == FN_SELECT) ? in_client_hash : in_ring_point;
      bidx_r    <= in_backend_index;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r    <= NW'(1);
      thr_r   <= 8'd3;
      ticks_r <= 16'd30;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NUM_BACKENDS: nb_r    <= cfg_wdata[NW-1:0];
        CFG_THRESHOLD:    thr_r   <= cfg_wdata[7:0];
        CFG_COOLDOWN:     ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Derived values
  assign n_act     = (32'(nb_r) > 32'(MAX_BACKENDS)) ? NW'(MAX_BACKENDS) : nb_r;
  assign cand      = (rr_r < n_act) ? rr_r : '0;
  assign cand_inc  = {1'b0, cand} + 1'b1;
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign pos_wrap  = (pos_r >= count_r) ? '0 : pos_r;
  assign owner     = rd_data_r.owner;
  assign owner_busy = armed_r[owner] && (left_r[owner] != '0);
  assign cand_busy = (cand < NW'(HSLOTS)) && armed_r[cand[BIW-1:0]] &&
                     (left_r[cand[BIW-1:0]] != '0);
  assign bidx_used = 32'(bidx_r) < 32'(MAX_BACKENDS);
  assign fail_inc  = (fail_r[bidx_r] == 8'hFF) ? 8'hFF : fail_r[bidx_r] + 8'd1;

  // Read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_MID:  rd_addr = mid[RAW-1:0];
      RD_POS:  rd_addr = pos_wrap[RAW-1:0];
      RD_LO:   rd_addr = lo_r[RAW-1:0];
      RD_PREV: rd_addr = RAW'(j_r - 1'b1);
      default: rd_addr = '0;
    endcase
  end

  // Ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (cmd.sh_move)        mem[j_r[RAW-1:0]]  <= rd_data_r;
    else if (cmd.ins_write) mem[lo_r[RAW-1:0]] <= '{hash: key_r, owner: bidx_r};
  end

  // Ring count and round-robin pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rr_r    <= '0;
    end else begin
      if (cmd.clear)          count_r <= '0;
      else if (cmd.ins_write) count_r <= count_r + 1'b1;
      if (cmd.clear)       rr_r <= '0;
      else if (cmd.rr_try) rr_r <= (cand_inc >= {1'b0, n_act}) ? '0 : cand_inc[NW-1:0];
    end
  end

  // Search, walk and shift pointers
  always_ff @(posedge clk) begin
    if (cmd.bs_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end else if (cmd.bs_step) begin
      if (rd_data_r.hash < key_r) lo_r <= mid + 1'b1;
      else                        hi_r <= mid;
    end
    if (cmd.wk_init)      pos_r <= lo_r;
    else if (cmd.wk_wrap) pos_r <= pos_wrap;
    else if (cmd.wk_next) pos_r <= pos_r + 1'b1;
    if (cmd.wk_init || cmd.rr_init)      i_r <= '0;
    else if (cmd.wk_next || cmd.rr_try)  i_r <= i_r + 1'b1;
    if (cmd.sh_init)      j_r <= count_r;
    else if (cmd.sh_move) j_r <= j_r - 1'b1;
  end

  // Health state per backend
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HSLOTS; k++) begin
        fail_r[k]  <= '0;
        armed_r[k] <= 1'b0;
        left_r[k]  <= '0;
      end
    end else begin
      if (cmd.tick) begin
        for (int k = 0; k < HSLOTS; k++)
          if (armed_r[k] && left_r[k] != '0) left_r[k] <= left_r[k] - 16'd1;
      end
      if (cmd.report_ok && bidx_used) begin
        fail_r[bidx_r]  <= '0;
        armed_r[bidx_r] <= 1'b0;
        left_r[bidx_r]  <= '0;
      end
      if (cmd.report_fail && bidx_used) begin
        fail_r[bidx_r] <= fail_inc;
        if (fail_inc >= thr_r) begin
          armed_r[bidx_r] <= 1'b1;
          left_r[bidx_r]  <= ticks_r;
        end
      end
      // an expired cooldown is cleared by the check that finds it
      if (cmd.wk_hit && armed_r[owner]) begin
        armed_r[owner] <= 1'b0;
        fail_r[owner]  <= '0;
      end
      if (cmd.rr_try && !cand_busy && cand < NW'(HSLOTS) && armed_r[cand[BIW-1:0]]) begin
        armed_r[cand[BIW-1:0]] <= 1'b0;
        fail_r[cand[BIW-1:0]]  <= '0;
      end
    end
  end

  // Result staging and output register
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      unique case (cmd.res_status)
        ST_RING: res_be_r <= owner;
        ST_RR:   res_be_r <= cand[BIW-1:0];
        default: res_be_r <= '0;
      endcase
    end
    if (cmd.res_load) begin
      out_status_r <= res_status_r;
      out_be_r     <= res_be_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                      out_valid_r <= 1'b0;
    else if (cmd.res_load)           out_valid_r <= 1'b1;
    else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_chosen_backend = out_be_r;

  // Status to the sequencer
  always_comb begin
    sts.func       = func_r;
    sts.present    = present_r;
    sts.n_zero     = (n_act == '0);
    sts.ring_empty = (count_r == '0);
    sts.ring_full  = (count_r >= RCW'(RING_DEPTH));
    sts.lo_lt_hi   = (lo_r < hi_r);
    sts.pos_lt_cnt = (lo_r < count_r);
    sts.dup_hit    = (rd_data_r.hash == key_r);
    sts.walk_done  = (i_r == n_act);
    sts.owner_ok   = ({1'b0, owner} < n_act) && !owner_busy;
    sts.rr_avail   = !cand_busy;
    sts.sh_done    = (j_r == lo_r);
    sts.out_full   = out_valid_r;
  end

endmodule

[design/hab_checker.sv]
// ----------------------------------------------------------------------------
// hab_checker
// Port-level checks for the backend selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hab_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [3:0] out_chosen_backend
);
  import hab_pkg::*;

  // a waiting result beat is not withdrawn
  `HAB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")

  // fallback and no-backend beats always name backend 0
  `HAB_ASSERT(a_zero_pick, clk, rst_n, out_valid && (out_status == ST_FALLBACK || out_status == ST_NONE) |-> out_chosen_backend == 4'd0, "nonzero backend on fallback")

  // after reset no result is pending
  `HAB_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "result after reset")

  // an accepted request is being worked on, so the next cycle takes none
  `HAB_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "second request taken")

endmodule

bind health_aware_backend_selector_core hab_checker u_hab_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_chosen_backend (out_ch.chosen_backend)
);
